/* sv/lrb_pkg.sv */
package lrb_pkg;

   // store geometry
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // field widths
   localparam int LEN_W    = 11;
   localparam int LAT_W    = 10;
   localparam int OFS_W    = 10;
   localparam int RUN_W    = 7;
   localparam int SAMPLE_W = 32;
   localparam int MAX_RUN  = 64;

   // request word layout
   localparam int REQ_TYPE_W  = 2;
   localparam int SAMPLE_LSB  = 0;
   localparam int RUN_LSB     = SAMPLE_LSB + SAMPLE_W;
   localparam int OFS_LSB     = RUN_LSB + RUN_W;
   localparam int REQ_TDATA_W = ((OFS_LSB + OFS_W + 7) / 8) * 8;

   // config port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LEN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LATENCY = 2'd1;

   localparam logic [LEN_W-1:0] LEN_MIN   = 11'd2;
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(STORE_DEPTH);
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SKIP  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_PEEK  = 2'd3;

   // remainder unit step counter
   localparam int REM_CNT_W = $clog2(OFS_W + 1);

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] rem;
   } rem_rsp_type;

   typedef struct packed {
      logic                last;
      logic [SAMPLE_W-1:0] sample;
   } rsp_word_type;

endpackage

/* sv/lrb_rem.sv */
// offset modulo ring length, one quotient bit per cycle
module lrb_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lrb_pkg::OFS_W-1:0]  dividend,
   input  logic [lrb_pkg::LEN_W-1:0]  divisor,
   output lrb_pkg::rem_rsp_type       rsp
);

   logic                              busy_ff, busy_in;
   logic [lrb_pkg::REM_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [lrb_pkg::ADDR_W-1:0]        rem_ff, rem_in;
   logic [lrb_pkg::OFS_W-1:0]         dvd_ff, dvd_in;
   logic [lrb_pkg::LEN_W-1:0]         trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      trial   = lrb_pkg::LEN_W'({rem_ff, dvd_ff[lrb_pkg::OFS_W-1]});
      if (trial >= divisor) begin
         trial = trial - divisor;
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = lrb_pkg::REM_CNT_W'(lrb_pkg::OFS_W);
         rem_in  = '0;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = lrb_pkg::ADDR_W'(trial);
            dvd_in = {dvd_ff[lrb_pkg::OFS_W-2:0], 1'b0};
            cnt_in = cnt_ff - lrb_pkg::REM_CNT_W'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign rsp.done = busy_ff && (cnt_ff == '0);
   assign rsp.rem  = rem_ff;

endmodule

/* sv/latency_ring_buffer_unit.sv */
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tuser: req_type; tdata: sample, run, peek offset
// rsp     | out | rsp_tvalid/rsp_tready | tdata: sample_out; tlast: last_of_run
// csr     | in  | csr_we                | csr_index selects length or latency, csr_wdata
//
// a write is done in S_IDLE; read and peek fetch their samples one at a time, set by
// the single port of the sample memory, and no request is taken until the run ends
// a peek first waits for the offset remainder (one bit per cycle) and the add
// a skip steps over the skipped entries one at a time
// after reset and after every length or latency write the memory is swept to zero,
// during which no word is taken on req
// a two-word output queue keeps reads going while rsp stalls; reads pause when full
module latency_ring_buffer_unit (
   input  logic                               clock,
   input  logic                               reset,
   // req_type
   input  logic [lrb_pkg::REQ_TYPE_W-1:0]     req_tuser,
   // sample_in [31:0], run_length [38:32], peek_offset [48:39], zero fill above
   input  logic [lrb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_out [31:0]
   output logic [lrb_pkg::SAMPLE_W-1:0]       rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [lrb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lrb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_REM   = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_SKIP  = 3'd4;

   // wrap a pointer step at the ring length
   function automatic logic [lrb_pkg::ADDR_W-1:0] wrap_inc(
      input logic [lrb_pkg::ADDR_W-1:0] ptr,
      input logic [lrb_pkg::LEN_W-1:0]  len
   );
      logic [lrb_pkg::LEN_W-1:0] nxt;
      nxt = lrb_pkg::LEN_W'(ptr) + lrb_pkg::LEN_W'(1);
      if (nxt == len) begin
         return '0;
      end
      return lrb_pkg::ADDR_W'(nxt);
   endfunction

   // config registers
   logic [lrb_pkg::LEN_W-1:0]    length_ff, length_in;
   logic [lrb_pkg::LAT_W-1:0]    latency_ff, latency_in;
   logic [lrb_pkg::LEN_W-1:0]    len_eff;
   logic [lrb_pkg::ADDR_W-1:0]   lat_eff;
   logic                         csr_hit;

   // sequencer
   logic [2:0]                   state_ff, state_in;
   logic [lrb_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic [lrb_pkg::ADDR_W-1:0]   rp_ff, rp_in;
   logic [lrb_pkg::ADDR_W-1:0]   wp_ff, wp_in;
   logic [lrb_pkg::ADDR_W-1:0]   cur_ff, cur_in;
   logic [lrb_pkg::RUN_W-1:0]    cnt_ff, cnt_in;
   logic                         adv_ff, adv_in;
   logic [lrb_pkg::LEN_W-1:0]    peek_sum;

   // request fields
   logic                         req_accept;
   logic [lrb_pkg::REQ_TYPE_W-1:0] req_type;
   logic [lrb_pkg::SAMPLE_W-1:0] sample_in;
   logic [lrb_pkg::RUN_W-1:0]    run_length;
   logic [lrb_pkg::OFS_W-1:0]    peek_offset;
   logic [lrb_pkg::RUN_W-1:0]    run_sat;

   // sample memory
   logic [lrb_pkg::SAMPLE_W-1:0] store_mem [lrb_pkg::STORE_DEPTH];
   logic                         mem_we, mem_re;
   logic [lrb_pkg::ADDR_W-1:0]   mem_addr;
   logic [lrb_pkg::SAMPLE_W-1:0] mem_wdata;
   logic [lrb_pkg::SAMPLE_W-1:0] mem_rdata_ff;
   logic                         inflight_ff, inflight_in;
   logic                         rd_last_ff, rd_last_in;

   // output queue, head is the word on rsp
   lrb_pkg::rsp_word_type        head_ff, head_in;
   lrb_pkg::rsp_word_type        tail_ff, tail_in;
   lrb_pkg::rsp_word_type        push_word;
   logic [1:0]                   occ_ff, occ_in;
   logic [1:0]                   occ_after;
   logic [2:0]                   slots_used;
   logic                         pop, push, can_issue;

   // remainder unit
   logic                         rem_start;
   lrb_pkg::rem_rsp_type         rem_rsp;

   lrb_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (peek_offset),
      .divisor  (len_eff),
      .rsp      (rem_rsp)
   );

   // unpack request word
   assign req_type    = req_tuser;
   assign sample_in   = req_tdata[lrb_pkg::SAMPLE_LSB +: lrb_pkg::SAMPLE_W];
   assign run_length  = req_tdata[lrb_pkg::RUN_LSB +: lrb_pkg::RUN_W];
   assign peek_offset = req_tdata[lrb_pkg::OFS_LSB +: lrb_pkg::OFS_W];
   assign run_sat     = (run_length > lrb_pkg::RUN_W'(lrb_pkg::MAX_RUN))
                        ? lrb_pkg::RUN_W'(lrb_pkg::MAX_RUN) : run_length;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // clamp length into the store and latency below length
   always_comb begin
      priority if (length_ff < lrb_pkg::LEN_MIN) begin
         len_eff = lrb_pkg::LEN_MIN;
      end else if (length_ff > lrb_pkg::LEN_MAX) begin
         len_eff = lrb_pkg::LEN_MAX;
      end else begin
         len_eff = length_ff;
      end
      if (lrb_pkg::LEN_W'(latency_ff) >= len_eff) begin
         lat_eff = lrb_pkg::ADDR_W'(len_eff - lrb_pkg::LEN_W'(1));
      end else begin
         lat_eff = lrb_pkg::ADDR_W'(latency_ff);
      end
   end

   // queue space counts the read still in the memory pipe
   assign pop        = rsp_tvalid && rsp_tready;
   assign push       = inflight_ff;
   assign slots_used = 3'(occ_ff) + 3'(inflight_ff) - 3'(pop);
   assign can_issue  = (slots_used < 3'd2);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      adv_in     = adv_ff;
      length_in  = length_ff;
      latency_in = latency_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = cur_ff;
      mem_wdata  = '0;
      rem_start  = 1'b0;
      peek_sum   = lrb_pkg::LEN_W'(rp_ff) + lrb_pkg::LEN_W'(rem_rsp.rem);
      if (peek_sum >= len_eff) begin
         peek_sum = peek_sum - len_eff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // zero sweep over the whole store
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + lrb_pkg::ADDR_W'(1);
            if (clr_ff == lrb_pkg::ADDR_W'(lrb_pkg::STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
               rp_in    = '0;
               wp_in    = lat_eff;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_type)
                  lrb_pkg::REQ_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = wp_ff;
                     mem_wdata = sample_in;
                     wp_in     = wrap_inc(wp_ff, len_eff);
                  end
                  lrb_pkg::REQ_READ: begin
                     if (run_sat != '0) begin
                        cur_in   = rp_ff;
                        cnt_in   = run_sat;
                        adv_in   = 1'b1;
                        state_in = S_EMIT;
                     end
                  end
                  lrb_pkg::REQ_SKIP: begin
                     if (run_sat != '0) begin
                        cur_in   = rp_ff;
                        cnt_in   = run_sat;
                        state_in = S_SKIP;
                     end
                  end
                  lrb_pkg::REQ_PEEK: begin
                     if (run_sat != '0) begin
                        cnt_in    = run_sat;
                        adv_in    = 1'b0;
                        rem_start = 1'b1;
                        state_in  = S_REM;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_REM: begin
            // peek start = read pointer plus offset mod length
            if (rem_rsp.done) begin
               cur_in   = lrb_pkg::ADDR_W'(peek_sum);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (can_issue) begin
               mem_re   = 1'b1;
               mem_addr = cur_ff;
               cur_in   = wrap_inc(cur_ff, len_eff);
               cnt_in   = cnt_ff - lrb_pkg::RUN_W'(1);
               if (cnt_ff == lrb_pkg::RUN_W'(1)) begin
                  state_in = S_IDLE;
                  if (adv_ff) begin
                     rp_in = wrap_inc(cur_ff, len_eff);
                  end
               end
            end
         end
         S_SKIP: begin
            cur_in = wrap_inc(cur_ff, len_eff);
            cnt_in = cnt_ff - lrb_pkg::RUN_W'(1);
            if (cnt_ff == lrb_pkg::RUN_W'(1)) begin
               rp_in    = wrap_inc(cur_ff, len_eff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // any known register write restarts the ring with a fresh sweep
      csr_hit = 1'b0;
      if (csr_we) begin
         priority if (csr_index == lrb_pkg::CSR_LENGTH) begin
            length_in = csr_wdata;
            csr_hit   = 1'b1;
         end else if (csr_index == lrb_pkg::CSR_LATENCY) begin
            latency_in = csr_wdata[lrb_pkg::LAT_W-1:0];
            csr_hit    = 1'b1;
         end else begin
            csr_hit = 1'b0;
         end
      end
      if (csr_hit) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   assign inflight_in = mem_re;
   assign rd_last_in  = mem_re && (cnt_ff == lrb_pkg::RUN_W'(1));

   // single-port sample memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_addr];
      end
   end

   // output queue
   always_comb begin
      push_word.last   = rd_last_ff;
      push_word.sample = mem_rdata_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      occ_after        = occ_ff - 2'(pop);
      if (pop) begin
         head_in = tail_ff;
      end
      if (push) begin
         if (occ_after == 2'd0) begin
            head_in = push_word;
         end else begin
            tail_in = push_word;
         end
      end
      occ_in = occ_after + 2'(push);
   end

   assign rsp_tvalid = (occ_ff != 2'd0);
   assign rsp_tdata  = head_ff.sample;
   assign rsp_tlast  = head_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         rp_ff       <= '0;
         wp_ff       <= '0;
         cur_ff      <= '0;
         cnt_ff      <= '0;
         adv_ff      <= 1'b0;
         length_ff   <= lrb_pkg::LEN_RESET;
         latency_ff  <= '0;
         inflight_ff <= 1'b0;
         occ_ff      <= 2'd0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         cur_ff      <= cur_in;
         cnt_ff      <= cnt_in;
         adv_ff      <= adv_in;
         length_ff   <= length_in;
         latency_ff  <= latency_in;
         inflight_ff <= inflight_in;
         occ_ff      <= occ_in;
      end
      rd_last_ff <= rd_last_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
   end

   // queue plus memory pipe never hold more than two words
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (3'(occ_ff) + 3'(inflight_ff)) <= 3'd2)
      else $error("output queue overfilled");

   // pointers stay inside the ring between requests
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         ((lrb_pkg::LEN_W'(rp_ff) < len_eff) && (lrb_pkg::LEN_W'(wp_ff) < len_eff)))
      else $error("ring pointer beyond length");

   // remainder result lies below the length
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_rsp.done |-> (lrb_pkg::LEN_W'(rem_rsp.rem) < len_eff))
      else $error("peek remainder out of range");

   // a run in progress always has samples left
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) || (state_ff == S_SKIP)) |-> (cnt_ff != '0))
      else $error("empty run in progress");

   // the last word of a run leaves the sequencer idle afterwards
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (mem_re && (cnt_ff == lrb_pkg::RUN_W'(1)) && !csr_hit) |=> (state_ff == S_IDLE))
      else $error("run did not end after its last read");

endmodule
